// File: rtl/core/pli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list package
// Shared codes, widths and the result record of the positional list block.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int MODE_W = 3;
    localparam int CNT_W  = 8;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_LAST,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]         entry_count;
        logic signed [DATA_W-1:0] read_value;
        t_status                  status;
    } t_result;

endpackage

// File: rtl/core/pli_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list entry memory
// Simple dual-port storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pli_mem #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [pli_pkg::DATA_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [pli_pkg::DATA_W-1:0] o_rdata
);
    import pli_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list sequencer
// Checks each request, then for an insert or delete moves entries one per cycle through the memory.
// ----------------------------------------------------------------------------
module pli_ctrl #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7,
    parameter int CW       = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pli_pkg::MODE_W-1:0]        i_mode,
    input  logic [pli_pkg::POS_W-1:0]         i_position,
    input  logic signed [pli_pkg::DATA_W-1:0] i_data_value,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output pli_pkg::t_result                  o_result,
    output logic                              o_mem_we,
    output logic [AW-1:0]                     o_mem_waddr,
    output logic [pli_pkg::DATA_W-1:0]        o_mem_wdata,
    output logic                              o_mem_re,
    output logic [AW-1:0]                     o_mem_raddr,
    input  logic [pli_pkg::DATA_W-1:0]        i_mem_rdata
);
    import pli_pkg::*;

    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_W-1:0]     r_val, n_val;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;
    logic                  r_wr_pend, n_wr_pend;
    logic [CW-1:0]         r_left, n_left;
    t_status               r_status, n_status;
    logic [DATA_W-1:0]     r_rdval, n_rdval;

    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_cnt_x;
    logic [CW-1:0]         w_cnt_m1;
    logic [AW-1:0]         w_pos_a;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_is_ins;
    logic                  w_shift_ins;
    logic                  w_shift_del;
    t_status               w_exec_status;

    assign w_pos_x     = XW'(r_pos);
    assign w_cnt_x     = XW'(r_count);
    assign w_cnt_m1    = r_count - 1'b1;
    assign w_pos_a     = w_pos_x[AW-1:0];
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_is_ins    = (r_mode == MODE_INSERT);
    assign w_shift_ins = (w_pos_x != w_cnt_x);
    assign w_shift_del = (w_pos_x != XW'(w_cnt_m1));

    // Full and empty take precedence over the index check.
    always_comb begin
        case (r_mode)
            MODE_INSERT: begin
                if (w_full) w_exec_status = ST_FULL;
                else if (w_pos_x > w_cnt_x) w_exec_status = ST_RANGE;
                else w_exec_status = ST_OK;
            end
            MODE_UPDATE, MODE_DELETE, MODE_READ: begin
                if (w_empty) w_exec_status = ST_EMPTY;
                else if (w_pos_x >= w_cnt_x) w_exec_status = ST_RANGE;
                else w_exec_status = ST_OK;
            end
            default: w_exec_status = ST_OK;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (w_exec_status == ST_OK) begin
                    case (r_mode)
                        MODE_INSERT: if (w_shift_ins) n_state = S_SHIFT;
                        MODE_DELETE: if (w_shift_del) n_state = S_SHIFT;
                        MODE_READ:   n_state = S_READ;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_left == '0) n_state = S_LAST;
            end
            S_LAST:  n_state = S_DONE;
            S_READ:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory port control.
    always_comb begin
        n_count     = r_count;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_val       = r_val;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_left      = r_left;
        n_status    = r_status;
        n_rdval     = r_rdval;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = w_pos_a;
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = w_pos_a;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_pos   = i_position;
                    n_val   = i_data_value;
                    n_rdval = '0;
                end
            end
            S_EXEC: begin
                n_status  = w_exec_status;
                n_wr_pend = 1'b0;
                if (w_exec_status == ST_OK) begin
                    case (r_mode)
                        MODE_INSERT: begin
                            if (w_shift_ins) begin
                                n_rd_addr = AW'(w_cnt_m1);
                                n_left    = CW'(w_cnt_x - w_pos_x);
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        MODE_UPDATE: o_mem_we = 1'b1;
                        MODE_DELETE: begin
                            if (w_shift_del) begin
                                n_rd_addr = w_pos_a + 1'b1;
                                n_left    = CW'(XW'(w_cnt_m1) - w_pos_x);
                            end else begin
                                n_count = w_cnt_m1;
                            end
                        end
                        MODE_READ:  o_mem_re = 1'b1;
                        MODE_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                // Each word read last cycle is written one slot up (insert) or down.
                if (r_wr_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_wr_addr;
                    o_mem_wdata = i_mem_rdata;
                end
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_rd_addr;
                    n_wr_addr   = w_is_ins ? r_rd_addr + 1'b1 : r_rd_addr - 1'b1;
                    n_rd_addr   = w_is_ins ? r_rd_addr - 1'b1 : r_rd_addr + 1'b1;
                    n_left      = r_left - 1'b1;
                    n_wr_pend   = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                end
            end
            S_LAST: begin
                if (w_is_ins) begin
                    o_mem_we = 1'b1;
                    n_count  = r_count + 1'b1;
                end else begin
                    n_count = w_cnt_m1;
                end
            end
            S_READ: n_rdval = i_mem_rdata;
            S_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_left    <= n_left;
        r_status  <= n_status;
        r_rdval   <= n_rdval;
    end

    assign o_result.status      = r_status;
    assign o_result.read_value  = r_rdval;
    assign o_result.entry_count = CNT_W'(r_count);

`ifndef SYNTHESIS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("memory read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_res_valid && !o_mem_we && !o_mem_re))
        else $error("request taken while sequencer busy");

    a_count_stable_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |=> $stable(r_count))
        else $error("count changed during an entry move");
`endif

endmodule

// File: rtl/core/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list with insert and delete at an index
// Dense ordered list of signed 32-bit values held in a dual-port memory.
// ----------------------------------------------------------------------------
// Each request carries a mode (insert, update, delete, read, clear), a
// position and a value, and produces exactly one response with a status, the
// value read (zero unless a read succeeds) and the entry count afterwards.
// Requests are handled one at a time. For an insert at a position below the
// count, or a delete below the last entry, the entries from the position
// upward (insert) or above it (delete) move one per cycle, each read from
// the memory's read port and written back one slot away through its write
// port on the following cycle. The memory is not cleared after reset; only
// entries below the count are ever read. A finished response waits in an
// output register, so the next request can be taken while the previous
// response is still being held off.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
    parameter int CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] position, [39:8] data_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [1:0] status, [33:2] read_value,
                                        // [41:34] entry_count, [47:42] zero
);
    import pli_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_result;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_rdata;

    logic              r_out_valid, n_out_valid;
    t_result           r_out_data, n_out_data;

    pli_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_mode       (s_axis_tuser),
        .i_position   (s_axis_tdata[7:0]),
        .i_data_value (s_axis_tdata[39:8]),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_result     (w_result),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_re     (w_mem_re),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    pli_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // The output register takes a new response whenever it is empty or being
    // drained in the same cycle.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_data.entry_count, r_out_data.read_value,
                            r_out_data.status};

endmodule

// File: tb/sv/positional_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list testbench
// Streams insert, update, delete, read and clear requests into the list block
// and checks every response against a typed-in one or a cycle-free shadow list.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. It covers the empty list,
// positions just past the end, the extreme values and the unused modes, with
// the expected response typed in where it is obvious. A random phase follows.
// It fills the list to capacity twice and otherwise drifts between growing and
// shrinking the list, so that insert and delete shift long runs of entries.
// Both stream sides pause at random, except for one stretch with no pauses.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;

    import pli_pkg::*;

    localparam int LIST_CAP    = 128;
    localparam int CLK_HALF    = 2;
    localparam int IDLE_PCT    = 38;
    localparam int TOTAL_REQS  = 925;       // directed table plus about 900 random
    localparam int RUN_LIMIT   = 2_000_000; // cycles; the slowest clean run is far below
    localparam int PRINT_CAP   = 100;

    // Modes 5 to 7 carry no operation; the block still answers each of them.
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

    // One row of the directed table. When fixed is set, the response is the
    // one typed into the row; otherwise the shadow list supplies it.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        bit                fixed;
        t_status           st;
        logic [DATA_W-1:0] rd;
        logic [CNT_W-1:0]  cnt;
    } t_req_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;          // [7:0] position, [39:8] data_value
    logic [2:0]  s_axis_tuser = MODE_INSERT; // [2:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;               // [1:0] status, [33:2] read_value,
                                             // [41:34] entry_count, [47:42] zero

    // Shadow of the list: contents, length and the responses still owed.
    logic [DATA_W-1:0] list_words [LIST_CAP];
    int                list_len = 0;
    t_result           pending_responses [$];

    t_req_row    directed_rows [$];
    bit          fixed_next = 1'b0;
    t_result     fixed_resp;
    bit          steady = 1'b0;  // set while neither side may pause
    bit          grow_bias = 1'b1;
    int          seg_left = 0;
    int          sent_reqs = 0;
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;

    positional_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Applies one request to the shadow list and returns the response it owes.
    // The full test comes before the index test on insert, and the empty test
    // before the index test on update, delete and read.
    function automatic t_result apply_list_op(input logic [MODE_W-1:0] mode,
                                              input logic [POS_W-1:0]  pos,
                                              input logic [DATA_W-1:0] val);
        t_result res;
        int      i;
        res.status     = ST_OK;
        res.read_value = '0;
        case (mode)
            MODE_INSERT: begin
                if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            MODE_UPDATE, MODE_DELETE, MODE_READ: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else if (mode == MODE_UPDATE) begin
                    list_words[pos] = val;
                end else if (mode == MODE_DELETE) begin
                    for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end else begin
                    res.read_value = list_words[pos];
                end
            end
            MODE_CLEAR: begin
                // Entries stay as they are; only the length drops to zero.
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = list_len[CNT_W-1:0];
        return res;
    endfunction

    function automatic t_req_row mk_row(input logic [MODE_W-1:0] mode,
                                        input logic [POS_W-1:0]  pos,
                                        input logic [DATA_W-1:0] val,
                                        input bit                fixed,
                                        input t_status           st,
                                        input logic [DATA_W-1:0] rd,
                                        input logic [CNT_W-1:0]  cnt);
        t_req_row row;
        row.mode  = mode;
        row.pos   = pos;
        row.val   = val;
        row.fixed = fixed;
        row.st    = st;
        row.rd    = rd;
        row.cnt   = cnt;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_cnt < PRINT_CAP) begin
            $display("[%0t] mismatch: %s got 0x%08h expected 0x%08h", $time, what, got, want);
        end
        mismatch_cnt++;
    endtask

    // Sends one request. Entered and left at a falling edge; the valid line is
    // written once per step, so a back-to-back request keeps it high.
    task automatic push_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        t_result pred;
        steady = (sent_reqs >= 320) && (sent_reqs < 440);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, 8'($urandom)};
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {val, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        // Accepted at this edge: the shadow list moves on now.
        pred = apply_list_op(mode, pos, val);
        pending_responses.push_back(fixed_next ? fixed_resp : pred);
        fixed_next = 1'b0;
        sent_reqs++;
        @(negedge i_clk);
    endtask

    // Clear, then load to capacity by appending, then poke at the full list:
    // inserts fail as full even at a bad position, and a delete at the front
    // shifts every entry after the first.
    task automatic bulk_load();
        int k;
        push_request(MODE_CLEAR, 8'($urandom), $urandom);
        for (k = 0; k < LIST_CAP; k++) push_request(MODE_INSERT, list_len[POS_W-1:0], $urandom);
        push_request(MODE_INSERT, 8'd200, $urandom);
        push_request(MODE_INSERT, 8'($urandom_range(0, LIST_CAP)), $urandom);
        push_request(MODE_READ, 8'(LIST_CAP - 1), $urandom);
        push_request(MODE_UPDATE, 8'(LIST_CAP - 1), $urandom);
        push_request(MODE_READ, 8'(LIST_CAP), $urandom);
        push_request(MODE_DELETE, 8'd0, $urandom);
        push_request(MODE_INSERT, 8'd0, $urandom);
    endtask

    // One random request. Most are well formed for the current length; the
    // rest are clears, unused modes and requests at any position at all.
    task automatic push_random();
        int                r;
        int                op;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        if (seg_left == 0) begin
            grow_bias = $urandom_range(0, 1);
            seg_left  = $urandom_range(20, 60);
        end
        seg_left--;
        r   = $urandom_range(0, 99);
        op  = $urandom_range(0, 99);
        pos = 8'($urandom);
        if (r < 2) begin
            mode = MODE_CLEAR;
        end else if (r < 6) begin
            mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        end else if (r < 14) begin
            mode = 3'($urandom_range(MODE_INSERT, MODE_READ));
        end else if (list_len == 0 || op < (grow_bias ? 55 : 15)) begin
            mode = MODE_INSERT;
            pos  = 8'($urandom_range(0, list_len));
        end else begin
            if (op < (grow_bias ? 65 : 30)) begin
                mode = MODE_UPDATE;
            end else if (op < 80) begin
                mode = MODE_DELETE;
            end else begin
                mode = MODE_READ;
            end
            pos = 8'($urandom_range(0, list_len - 1));
        end
        push_request(mode, pos, $urandom);
    endtask

    // Response side: pause at random on the falling edge, check on the rising.
    always begin
        @(negedge i_clk);
        m_axis_tready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[41:0]);
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no request waiting", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_responses.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            end
        end
    end

    initial begin
        wait (cycle_cnt >= RUN_LIMIT);
        $display("positional_list_insert_delete_tb failed");
        $finish;
    end

    initial begin
        // Directed table. Values at the signed extremes land at both ends
        // and in the middle so the shifts are visible on later reads.
        directed_rows.push_back(mk_row(MODE_READ,   8'd0,   32'd0, 1, ST_EMPTY, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_UPDATE, 8'd0,   32'd5, 1, ST_EMPTY, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_DELETE, 8'd0,   32'd0, 1, ST_EMPTY, 32'd0, 8'd0));
        // On an empty list the empty test wins over a bad position.
        directed_rows.push_back(mk_row(MODE_DELETE, 8'd255, 32'd0, 1, ST_EMPTY, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd1,   32'd7, 1, ST_RANGE, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd0, 32'h8000_0000, 1, ST_OK, 32'd0, 8'd1));
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd1, 32'h7FFF_FFFF, 1, ST_OK, 32'd0, 8'd2));
        directed_rows.push_back(mk_row(MODE_READ, 8'd0, 32'd0, 1, ST_OK, 32'h8000_0000, 8'd2));
        directed_rows.push_back(mk_row(MODE_READ, 8'd1, 32'd0, 1, ST_OK, 32'h7FFF_FFFF, 8'd2));
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd0, 32'hFFFF_FFFF, 1, ST_OK, 32'd0, 8'd3));
        directed_rows.push_back(mk_row(MODE_READ, 8'd1, 32'd0, 1, ST_OK, 32'h8000_0000, 8'd3));
        // Insert at the count appends.
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd3, 32'd0, 1, ST_OK, 32'd0, 8'd4));
        directed_rows.push_back(mk_row(MODE_INSERT, 8'd5, 32'd1, 1, ST_RANGE, 32'd0, 8'd4));
        // Read at the count is one past the end.
        directed_rows.push_back(mk_row(MODE_READ, 8'd4,   32'd0, 1, ST_RANGE, 32'd0, 8'd4));
        directed_rows.push_back(mk_row(MODE_READ, 8'd255, 32'd0, 1, ST_RANGE, 32'd0, 8'd4));
        directed_rows.push_back(mk_row(MODE_UPDATE, 8'd2, 32'h55AA_55AA, 1, ST_OK, 32'd0, 8'd4));
        directed_rows.push_back(mk_row(MODE_READ, 8'd2, 32'd0, 1, ST_OK, 32'h55AA_55AA, 8'd4));
        directed_rows.push_back(mk_row(MODE_DELETE, 8'd1, 32'd0, 1, ST_OK, 32'd0, 8'd3));
        directed_rows.push_back(mk_row(MODE_READ,   8'd1, 32'd0, 0, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_DELETE, 8'd2, 32'd0, 0, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_RSVD_LO, 8'd0, 32'd0, 0, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_RSVD_HI, 8'd255, 32'hFFFF_FFFF, 0, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_UPDATE, 8'd2, 32'd9, 0, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_CLEAR, 8'd0, 32'd0, 1, ST_OK, 32'd0, 8'd0));
        directed_rows.push_back(mk_row(MODE_READ,  8'd0, 32'd0, 1, ST_EMPTY, 32'd0, 8'd0));

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            fixed_next             = directed_rows[n].fixed;
            fixed_resp.status      = directed_rows[n].st;
            fixed_resp.read_value  = directed_rows[n].rd;
            fixed_resp.entry_count = directed_rows[n].cnt;
            push_request(directed_rows[n].mode, directed_rows[n].pos, directed_rows[n].val);
        end

        // Random phase: a full load at the start and one more halfway.
        bulk_load();
        while (sent_reqs < TOTAL_REQS) begin
            if (sent_reqs >= 450 && sent_reqs < 460) bulk_load();
            push_random();
        end
        s_axis_tvalid = 1'b0;

        // Drain, then give a stray response time to show up.
        wait (pending_responses.size() == 0);
        repeat (LIST_CAP + 16) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("positional_list_insert_delete_tb passed");
        end else begin
            $display("positional_list_insert_delete_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pli_pkg.sv
rtl/core/pli_mem.sv
rtl/core/pli_ctrl.sv
rtl/core/positional_list_insert_delete.sv
tb/sv/positional_list_insert_delete_tb.sv
